// File: design/ptw_pkg.sv
package ptw_pkg;

    localparam int STORE_WORDS = 8192;
    localparam int PAGE_WORDS  = 512;
    localparam int TABLE_PAGES = STORE_WORDS / PAGE_WORDS;
    localparam int ADDR_W      = $clog2(STORE_WORDS);

    localparam int KIND_W  = 2;
    localparam int VA_W    = 48;
    localparam int WIDX_W  = 13;
    localparam int WORD_W  = 64;
    localparam int PA_W    = 52;
    localparam int STAT_W  = 2;
    localparam int PAGE_W  = 40;
    localparam int IDX_W   = 9;
    localparam int TOP_SHIFT = 39;

    localparam logic [KIND_W-1:0] KIND_WRITE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRANSLATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNMAP     = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STAT_W-1:0] ST_ABSENT     = 2'd1;
    localparam logic [STAT_W-1:0] ST_HUGE_BLOCK = 2'd2;
    localparam logic [STAT_W-1:0] ST_OUTSIDE    = 2'd3;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_HUGE    = 7;

    // microprogram
    typedef logic [3:0] t_step;

    typedef enum logic [2:0] {
        OP_ACCEPT = 3'd0,
        OP_WRITE  = 3'd1,
        OP_ISSUE  = 3'd2,
        OP_CHECK  = 3'd3,
        OP_FINISH = 3'd4
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] lvl;
        t_step      nxt;
    } t_uop;

    localparam t_step STEP_ACCEPT = 4'd0;
    localparam t_step STEP_WRITE  = 4'd1;
    localparam t_step STEP_ISSUE0 = 4'd2;
    localparam t_step STEP_CHECK0 = 4'd3;
    localparam t_step STEP_ISSUE1 = 4'd4;
    localparam t_step STEP_CHECK1 = 4'd5;
    localparam t_step STEP_ISSUE2 = 4'd6;
    localparam t_step STEP_CHECK2 = 4'd7;
    localparam t_step STEP_ISSUE3 = 4'd8;
    localparam t_step STEP_CHECK3 = 4'd9;
    localparam t_step STEP_FINISH = 4'd10;

    localparam logic [1:0] LVL_TOP = 2'd0;
    localparam logic [1:0] LVL_PTR = 2'd1;
    localparam logic [1:0] LVL_DIR = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    function automatic t_uop ucode_rom(input t_step step);
        t_uop u;
        case (step)
            STEP_ACCEPT: u = '{OP_ACCEPT, LVL_TOP,  STEP_FINISH};
            STEP_WRITE:  u = '{OP_WRITE,  LVL_TOP,  STEP_FINISH};
            STEP_ISSUE0: u = '{OP_ISSUE,  LVL_TOP,  STEP_CHECK0};
            STEP_CHECK0: u = '{OP_CHECK,  LVL_TOP,  STEP_ISSUE1};
            STEP_ISSUE1: u = '{OP_ISSUE,  LVL_PTR,  STEP_CHECK1};
            STEP_CHECK1: u = '{OP_CHECK,  LVL_PTR,  STEP_ISSUE2};
            STEP_ISSUE2: u = '{OP_ISSUE,  LVL_DIR,  STEP_CHECK2};
            STEP_CHECK2: u = '{OP_CHECK,  LVL_DIR,  STEP_ISSUE3};
            STEP_ISSUE3: u = '{OP_ISSUE,  LVL_LEAF, STEP_CHECK3};
            STEP_CHECK3: u = '{OP_CHECK,  LVL_LEAF, STEP_FINISH};
            STEP_FINISH: u = '{OP_FINISH, LVL_TOP,  STEP_ACCEPT};
            default:     u = '{OP_FINISH, LVL_TOP,  STEP_ACCEPT};
        endcase
        return u;
    endfunction

endpackage

// File: design/ptw_ifs.sv
interface ptw_req_if
    import ptw_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [VA_W-1:0]   virt_addr;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] word_data;

    modport source (output valid, kind, virt_addr, word_index, word_data, input ready);
    modport sink   (input valid, kind, virt_addr, word_index, word_data, output ready);
endinterface

interface ptw_rsp_if
    import ptw_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [PA_W-1:0]   phys_addr;
    logic              huge_page;
    logic [STAT_W-1:0] status;

    modport source (output valid, phys_addr, huge_page, status, input ready);
    modport sink   (input valid, phys_addr, huge_page, status, output ready);
endinterface

// File: design/four_level_page_table_walker.sv
// a table write runs the accept, write and finish steps; translate or unmap run an issue and
// a check step per level walked (an unmap leaf only the issue step) on the single
// registered-read port of the table store, one word at a time, so a walk holds the sequencer
// until it finishes; the result register lets the next word be accepted while a result waits
// synchronous active-low reset clears the step counter, output valid and root page;
// the table store is not cleared and must be written before it is walked
module four_level_page_table_walker
    import ptw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ptw_req_if.sink           i_req,
    ptw_rsp_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  logic [PAGE_W-1:0] i_cfg_data
);

    logic [WORD_W-1:0] mem [STORE_WORDS];

    t_step             r_upc, n_upc;
    logic [PAGE_W-1:0] r_root;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [VA_W-1:0]   r_va, n_va;
    logic [WIDX_W-1:0] r_widx, n_widx;
    logic [WORD_W-1:0] r_wdata, n_wdata;
    logic [WORD_W-1:0] r_rdata;
    logic [PA_W-1:0]   r_phys, n_phys;
    logic              r_huge, n_huge;
    logic [STAT_W-1:0] r_status, n_status;

    logic              r_out_valid, n_out_valid;
    logic [PA_W-1:0]   r_out_phys, n_out_phys;
    logic              r_out_huge, n_out_huge;
    logic [STAT_W-1:0] r_out_status, n_out_status;

    t_uop              uop;
    logic [IDX_W-1:0]  lvl_idx;
    logic              page_inside;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we, mem_re;
    logic [WORD_W-1:0] mem_wdata;
    logic              out_free;
    logic [PAGE_W+IDX_W-1:0] slot_full;

    assign uop      = ucode_rom(r_upc);
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready     = (uop.op == OP_ACCEPT);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.phys_addr = r_out_phys;
    assign o_rsp.huge_page = r_out_huge;
    assign o_rsp.status    = r_out_status;

    always_comb begin
        case (uop.lvl)
            LVL_TOP:  lvl_idx = r_va[TOP_SHIFT +: IDX_W];
            LVL_PTR:  lvl_idx = r_va[TOP_SHIFT - IDX_W +: IDX_W];
            LVL_DIR:  lvl_idx = r_va[TOP_SHIFT - 2*IDX_W +: IDX_W];
            default:  lvl_idx = r_va[TOP_SHIFT - 3*IDX_W +: IDX_W];
        endcase
    end

    assign page_inside = (r_page < PAGE_W'(TABLE_PAGES));
    assign slot_full   = {r_page, lvl_idx};

    always_comb begin
        n_upc        = r_upc;
        n_page       = r_page;
        n_kind       = r_kind;
        n_va         = r_va;
        n_widx       = r_widx;
        n_wdata      = r_wdata;
        n_phys       = r_phys;
        n_huge       = r_huge;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_phys   = r_out_phys;
        n_out_huge   = r_out_huge;
        n_out_status = r_out_status;
        mem_addr     = slot_full[ADDR_W-1:0];
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wdata    = '0;

        case (uop.op)
            OP_ACCEPT: begin
                if (i_req.valid) begin
                    n_kind   = i_req.kind;
                    n_va     = i_req.virt_addr;
                    n_widx   = i_req.word_index;
                    n_wdata  = i_req.word_data;
                    n_page   = r_root;
                    n_phys   = '0;
                    n_huge   = 1'b0;
                    n_status = ST_DONE;
                    case (i_req.kind)
                        KIND_WRITE:               n_upc = STEP_WRITE;
                        KIND_TRANSLATE, KIND_UNMAP: n_upc = STEP_ISSUE0;
                        default:                  n_upc = uop.nxt;
                    endcase
                end
            end
            OP_WRITE: begin
                mem_addr  = ADDR_W'(r_widx);
                mem_we    = (32'(r_widx) < 32'(STORE_WORDS));
                mem_wdata = r_wdata;
                n_upc     = uop.nxt;
            end
            OP_ISSUE: begin
                if (!page_inside) begin
                    n_status = ST_OUTSIDE;
                    n_upc    = STEP_FINISH;
                end else if (uop.lvl == LVL_LEAF && r_kind == KIND_UNMAP) begin
                    // unmap clears the leaf whether present or not
                    mem_we = 1'b1;
                    n_upc  = STEP_FINISH;
                end else begin
                    mem_re = 1'b1;
                    n_upc  = uop.nxt;
                end
            end
            OP_CHECK: begin
                n_page = r_rdata[PAGE_W+11:12];
                if (!r_rdata[BIT_PRESENT]) begin
                    n_status = ST_ABSENT;
                    n_upc    = STEP_FINISH;
                end else if (uop.lvl == LVL_LEAF) begin
                    n_phys = {r_rdata[PA_W-1:12], r_va[11:0]};
                    n_upc  = uop.nxt;
                end else if (uop.lvl == LVL_DIR && r_rdata[BIT_HUGE]) begin
                    // 2 MB page ends the walk at the directory
                    if (r_kind == KIND_TRANSLATE) begin
                        n_phys = {r_rdata[PA_W-1:21], r_va[20:0]};
                        n_huge = 1'b1;
                    end else begin
                        n_status = ST_HUGE_BLOCK;
                    end
                    n_upc = STEP_FINISH;
                end else begin
                    n_upc = uop.nxt;
                end
            end
            OP_FINISH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_phys   = r_phys;
                    n_out_huge   = r_huge;
                    n_out_status = r_status;
                    n_upc        = uop.nxt;
                end
            end
            default: n_upc = STEP_ACCEPT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= STEP_ACCEPT;
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_root <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page       <= n_page;
        r_kind       <= n_kind;
        r_va         <= n_va;
        r_widx       <= n_widx;
        r_wdata      <= n_wdata;
        r_phys       <= n_phys;
        r_huge       <= n_huge;
        r_status     <= n_status;
        r_out_phys   <= n_out_phys;
        r_out_huge   <= n_out_huge;
        r_out_status <= n_out_status;
    end

endmodule

// File: sim/ptw_walk_checker.sv
`timescale 1ns / 1ps

module ptw_walk_checker
    import ptw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ptw_req_if                i_req,
    ptw_rsp_if                i_rsp,
    input  logic              i_cfg_we,
    input  logic [PAGE_W-1:0] i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked
);

    localparam int PAGE_SHIFT = 12;
    localparam int HUGE_SHIFT = 21;
    localparam int PRINT_CAP  = 100;

    typedef struct packed {
        logic [PA_W-1:0]   phys_addr;
        logic              huge_page;
        logic [STAT_W-1:0] status;
    } t_walk_result;

    logic [WORD_W-1:0] table_mirror [STORE_WORDS];
    logic [PAGE_W-1:0] root_page;
    t_walk_result      results_due[$];
    int                mismatches = 0;
    int                compared = 0;

    assign o_errors  = mismatches;
    assign o_checked = compared;
    assign o_pending = results_due.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t ptw: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // applies one word to the mirrored tables and returns the walk outcome
    function automatic t_walk_result walk_predict(input logic [KIND_W-1:0] kind,
                                                  input logic [VA_W-1:0]   va,
                                                  input logic [WIDX_W-1:0] widx,
                                                  input logic [WORD_W-1:0] wdata);
        t_walk_result      res;
        logic [PAGE_W-1:0] page;
        logic [WORD_W-1:0] entry;
        int                lvl;
        int                slot;
        res = '0;
        res.status = ST_DONE;
        if (kind == KIND_WRITE) begin
            if (int'(widx) < STORE_WORDS)
                table_mirror[widx] = wdata;
            return res;
        end
        if (kind != KIND_TRANSLATE && kind != KIND_UNMAP)
            return res;
        page = root_page;
        for (lvl = 0; lvl <= LVL_LEAF; lvl++) begin
            if (page >= TABLE_PAGES) begin
                res.status = ST_OUTSIDE;
                return res;
            end
            slot = int'(page) * PAGE_WORDS + int'(va[TOP_SHIFT - IDX_W * lvl +: IDX_W]);
            // unmap clears the leaf without looking at it
            if (lvl == LVL_LEAF && kind == KIND_UNMAP) begin
                table_mirror[slot] = '0;
                return res;
            end
            entry = table_mirror[slot];
            if (!entry[BIT_PRESENT]) begin
                res.status = ST_ABSENT;
                return res;
            end
            if (lvl == LVL_LEAF) begin
                res.phys_addr = {entry[PA_W-1:PAGE_SHIFT], va[PAGE_SHIFT-1:0]};
                return res;
            end
            // huge bit only counts at the directory level
            if (lvl == LVL_DIR && entry[BIT_HUGE]) begin
                if (kind == KIND_UNMAP) begin
                    res.status = ST_HUGE_BLOCK;
                end else begin
                    res.phys_addr = {entry[PA_W-1:HUGE_SHIFT], va[HUGE_SHIFT-1:0]};
                    res.huge_page = 1'b1;
                end
                return res;
            end
            page = entry[PA_W-1:PAGE_SHIFT];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_walk_result want;
        if (!i_rst_n) begin
            root_page = '0;
            results_due.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result word with nothing outstanding",
                                    64'(i_rsp.phys_addr), 64'd0);
                end else begin
                    want = results_due.pop_front();
                    if (i_rsp.phys_addr !== want.phys_addr)
                        report_mismatch("phys_addr", 64'(i_rsp.phys_addr),
                                        64'(want.phys_addr));
                    if (i_rsp.huge_page !== want.huge_page)
                        report_mismatch("huge_page", 64'(i_rsp.huge_page),
                                        64'(want.huge_page));
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", 64'(i_rsp.status), 64'(want.status));
                    compared++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                want = walk_predict(i_req.kind, i_req.virt_addr, i_req.word_index,
                                    i_req.word_data);
                results_due.push_back(want);
            end
            if (i_cfg_we)
                root_page = i_cfg_data;
        end
    end

endmodule

// File: sim/tb_four_level_page_table_walker.sv
`timescale 1ns / 1ps

module tb_four_level_page_table_walker;
    import ptw_pkg::*;

    localparam int PAGE_SHIFT  = 12;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 12;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [PAGE_W-1:0] cfg_data;
    int                chk_errors;
    int                chk_pending;
    int                chk_checked;

    ptw_req_if req_ch ();
    ptw_rsp_if rsp_ch ();

    four_level_page_table_walker u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    ptw_walk_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .i_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending),
        .o_checked  (chk_checked)
    );

    // what the stimulus believes the tables hold, so no walk touches an unwritten word
    logic [WORD_W-1:0] plan_words [STORE_WORDS];
    bit                plan_written [STORE_WORDS];
    logic [PAGE_W-1:0] plan_root = '0;
    logic [VA_W-1:0]   mapped_vas[$];

    bit calm = 1'b0;
    int hold_cycles = 0;
    int words_sent = 0;
    int n_write = 0;
    int n_translate = 0;
    int n_unmap = 0;
    int n_unused = 0;
    int root_settings = 0;
    int stall_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [WORD_W-1:0] make_entry(input int lvl);
        logic [WORD_W-1:0] entry;
        int                pick;
        entry = rand_word();
        pick = $urandom_range(0, 99);
        if (lvl != LVL_LEAF) begin
            if (pick < 80)
                entry[PA_W-1:PAGE_SHIFT] = PAGE_W'($urandom_range(0, TABLE_PAGES - 1));
            else if (pick < 90)
                entry[PA_W-1:PAGE_SHIFT] = PAGE_W'(TABLE_PAGES + $urandom_range(0, 3));
        end
        entry[BIT_PRESENT] = ($urandom_range(0, 9) != 0);
        if (lvl == LVL_DIR)
            entry[BIT_HUGE] = ($urandom_range(0, 3) == 0);
        return entry;
    endfunction

    // follows the planned tables; reports the first unwritten word the walk would read
    function automatic bit probe_walk(input logic [KIND_W-1:0] kind,
                                      input logic [VA_W-1:0] va,
                                      output int hole_slot, output int hole_lvl,
                                      output int cleared_slot);
        logic [PAGE_W-1:0] page;
        logic [WORD_W-1:0] entry;
        int                lvl;
        int                slot;
        hole_slot = -1;
        hole_lvl = 0;
        cleared_slot = -1;
        page = plan_root;
        for (lvl = 0; lvl <= LVL_LEAF; lvl++) begin
            if (page >= TABLE_PAGES)
                return 1'b1;
            slot = int'(page) * PAGE_WORDS + int'(va[TOP_SHIFT - IDX_W * lvl +: IDX_W]);
            if (lvl == LVL_LEAF && kind == KIND_UNMAP) begin
                cleared_slot = slot;
                return 1'b1;
            end
            if (!plan_written[slot]) begin
                hole_slot = slot;
                hole_lvl = lvl;
                return 1'b0;
            end
            entry = plan_words[slot];
            if (!entry[BIT_PRESENT] || (lvl == LVL_DIR && entry[BIT_HUGE]))
                return 1'b1;
            page = entry[PA_W-1:PAGE_SHIFT];
        end
        return 1'b1;
    endfunction

    // leaves valid high after the accepting edge; a gap before the next word or a root change lowers it
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [VA_W-1:0] va,
                             input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] wdata);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.virt_addr  <= va;
        req_ch.word_index <= widx;
        req_ch.word_data  <= wdata;
        do @(posedge clk); while (!req_ch.ready);
        words_sent++;
        case (kind)
            KIND_WRITE:     n_write++;
            KIND_TRANSLATE: n_translate++;
            KIND_UNMAP:     n_unmap++;
            default:        n_unused++;
        endcase
    endtask

    task automatic issue_write(input int slot, input logic [WORD_W-1:0] data);
        plan_words[slot] = data;
        plan_written[slot] = 1'b1;
        send_word(KIND_WRITE, VA_W'(rand_word()), WIDX_W'(slot), data);
    endtask

    // fills any missing table word on the path first, then walks
    task automatic issue_walk(input logic [KIND_W-1:0] kind, input logic [VA_W-1:0] va);
        int hole_slot;
        int hole_lvl;
        int cleared_slot;
        while (!probe_walk(kind, va, hole_slot, hole_lvl, cleared_slot))
            issue_write(hole_slot, make_entry(hole_lvl));
        if (cleared_slot >= 0) begin
            plan_words[cleared_slot] = '0;
            plan_written[cleared_slot] = 1'b1;
        end
        send_word(kind, va, WIDX_W'($urandom()), rand_word());
    endtask

    task automatic set_root_page(input logic [PAGE_W-1:0] page);
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (chk_pending != 0);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= page;
        @(posedge clk);
        cfg_we   <= 1'b0;
        plan_root = page;
        root_settings++;
    endtask

    // builds a present path for one address, then translates and maybe unmaps it
    task automatic map_and_probe();
        logic [VA_W-1:0]   va;
        logic [PAGE_W-1:0] page;
        logic [WORD_W-1:0] entry;
        int                lvl;
        int                slot;
        bit                huge;
        bit                done;
        va = VA_W'(rand_word());
        huge = ($urandom_range(0, 3) == 0);
        page = plan_root;
        done = 1'b0;
        for (lvl = 0; lvl <= LVL_LEAF && !done; lvl++) begin
            if (page >= TABLE_PAGES) begin
                done = 1'b1;
            end else begin
                slot = int'(page) * PAGE_WORDS + int'(va[TOP_SHIFT - IDX_W * lvl +: IDX_W]);
                entry = make_entry(lvl);
                entry[BIT_PRESENT] = 1'b1;
                if (lvl != LVL_LEAF && $urandom_range(0, 19) != 0)
                    entry[PA_W-1:PAGE_SHIFT] = PAGE_W'($urandom_range(0, TABLE_PAGES - 1));
                if (lvl == LVL_DIR)
                    entry[BIT_HUGE] = huge;
                issue_write(slot, entry);
                page = entry[PA_W-1:PAGE_SHIFT];
                if (lvl == LVL_DIR && huge)
                    done = 1'b1;
            end
        end
        repeat ($urandom_range(1, 4)) begin
            if (huge)
                issue_walk(KIND_TRANSLATE, {va[VA_W-1:21], 21'($urandom())});
            else
                issue_walk(KIND_TRANSLATE, {va[VA_W-1:PAGE_SHIFT], 12'($urandom())});
        end
        if ($urandom_range(0, 9) < 4) begin
            issue_walk(KIND_UNMAP, va);
            issue_walk(KIND_TRANSLATE, va);
        end
        mapped_vas.push_back(va);
        if (mapped_vas.size() > 64)
            void'(mapped_vas.pop_front());
    endtask

    task automatic random_phase(input int count);
        int               stop;
        int               pick;
        logic [VA_W-1:0]  va;
        stop = words_sent + count;
        while (words_sent < stop) begin
            if ($urandom_range(0, 49) == 0)
                calm = !calm;
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                map_and_probe();
            end else if (pick < 55) begin
                issue_walk(KIND_TRANSLATE, VA_W'(rand_word()));
            end else if (pick < 65) begin
                issue_walk(KIND_UNMAP, VA_W'(rand_word()));
            end else if (pick < 75 && mapped_vas.size() > 0) begin
                va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)]
                     ^ VA_W'($urandom_range(0, 'h1FFFFF));
                issue_walk($urandom_range(0, 2) == 0 ? KIND_UNMAP : KIND_TRANSLATE, va);
            end else if (pick < 87) begin
                issue_write($urandom_range(0, STORE_WORDS - 1), rand_word());
            end else if (pick < 97) begin
                issue_write($urandom_range(0, STORE_WORDS - 1),
                            make_entry($urandom_range(LVL_TOP, LVL_LEAF)));
            end else begin
                send_word(KIND_UNUSED, VA_W'(rand_word()), WIDX_W'($urandom()), rand_word());
            end
        end
    endtask

    task automatic directed_walks();
        logic [VA_W-1:0] va_a;
        va_a = {9'd1, 9'd2, 9'd3, 9'd4, 12'hFFF};
        // stray huge bits at top and pointer level must be ignored
        issue_write(1, {12'hFFF, 40'd1, 12'h081});
        issue_write(PAGE_WORDS + 2, {12'h000, 40'd2, 12'h081});
        issue_write(2 * PAGE_WORDS + 3, {12'h000, 40'd3, 12'h001});
        issue_write(3 * PAGE_WORDS + 4, {12'hFFF, 40'hFF_FFFF_FFFF, 12'hFFF});
        issue_walk(KIND_TRANSLATE, va_a);
        // 2 MB entry, translate at both ends of the page, unmap refused
        issue_write(2 * PAGE_WORDS + 5, {12'h000, 40'hFF_FFFF_FFFF, 12'h081});
        issue_walk(KIND_TRANSLATE, {9'd1, 9'd2, 9'd5, 21'h1FFFFF});
        issue_walk(KIND_TRANSLATE, {9'd1, 9'd2, 9'd5, 21'h0});
        issue_walk(KIND_UNMAP, {9'd1, 9'd2, 9'd5, 21'h0});
        // last-level table beyond the store
        issue_write(2 * PAGE_WORDS + 6, {12'h000, 40'd16, 12'h001});
        issue_walk(KIND_TRANSLATE, {9'd1, 9'd2, 9'd6, 9'd7, 12'h000});
        issue_walk(KIND_UNMAP, {9'd1, 9'd2, 9'd6, 9'd7, 12'h000});
        // absent leaf, then unmap of that absent leaf
        issue_write(3 * PAGE_WORDS + 8, '0);
        issue_walk(KIND_TRANSLATE, {9'd1, 9'd2, 9'd3, 9'd8, 12'h123});
        issue_walk(KIND_UNMAP, {9'd1, 9'd2, 9'd3, 9'd8, 12'h123});
        issue_walk(KIND_UNMAP, va_a);
        issue_walk(KIND_TRANSLATE, va_a);
        // not present at top, pointer and directory level
        issue_write(0, '0);
        issue_walk(KIND_TRANSLATE, '0);
        issue_write(PAGE_WORDS + 9, '0);
        issue_walk(KIND_TRANSLATE, {9'd1, 9'd9, 30'h0});
        issue_write(2 * PAGE_WORDS + 10, '0);
        issue_walk(KIND_TRANSLATE, {9'd1, 9'd2, 9'd10, 21'h0});
        issue_write(STORE_WORDS - 1, '1);
        send_word(KIND_UNUSED, '1, '1, '1);
    endtask

    initial begin : stimulus
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= KIND_WRITE;
        req_ch.virt_addr  <= '0;
        req_ch.word_index <= '0;
        req_ch.word_data  <= '0;
        cfg_we            <= 1'b0;
        cfg_data          <= '0;
        rst_n             <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_walks();
        random_phase(380);

        set_root_page(PAGE_W'(TABLE_PAGES - 1));
        hold_cycles = HOLD_CYCLES;
        random_phase(300);

        set_root_page(PAGE_W'(TABLE_PAGES));
        random_phase(40);
        set_root_page('1);
        random_phase(40);

        set_root_page(PAGE_W'($urandom_range(1, TABLE_PAGES - 2)));
        random_phase(380);
        set_root_page('0);
        random_phase(380);

        req_ch.valid <= 1'b0;
        do @(negedge clk); while (chk_pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("exercised %0d table writes, %0d translations, %0d unmaps, %0d unused-kind words",
                 n_write, n_translate, n_unmap, n_unused);
        $display("over %0d root page settings; %0d result words compared",
                 root_settings + 1, chk_checked);
        if (chk_errors == 0 && chk_pending == 0)
            $display("tb_four_level_page_table_walker: PASS");
        else
            $display("tb_four_level_page_table_walker: FAIL");
        $finish;
    end

    initial begin : drain
        int gap;
        rsp_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 6);
            // long back-pressure so the walker fills and stalls its input
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("tb_four_level_page_table_walker: FAIL");
            $finish;
        end
    end

endmodule
